>>> src/smms_pkg.sv
`default_nettype none
package smms_pkg;

	localparam int DEPTH_DEFAULT = 64;

	// field widths
	localparam int CMD_W    = 2;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 7;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SWAP = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage
`default_nettype wire

>>> src/stack_with_minmax_swap_top.sv
`default_nettype none
// Bounded LIFO stack of signed 32-bit words held in one synchronous RAM (one write
// port, one read port, registered read data). Each request carries a command in
// s_tuser: push stores s_tdata on top (status FULL and no change when the stack
// already holds DEPTH words), pop returns the top word (status EMPTY and 0 when
// nothing is held), swap exchanges the first minimum and first maximum in place.
// Every request gives exactly one result: pop_value and fill_count in m_tdata,
// status in m_tuser. Push, pop on empty, swap on empty and the unused code load
// the result directly; pop first waits on the registered read of the RAM; swap
// scans the held entries through the single read port, one entry per cycle,
// then drains the compare stage and writes back both slots on the one write
// port. The result sits in an output register, so a push is taken in the same
// cycle a previous result is being taken downstream. The RAM needs no clearing
// after reset: only entries below the fill count are ever read.
module stack_with_minmax_swap_top #(
	parameter int DEPTH = smms_pkg::DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] push_value
	input  wire logic [1:0]  s_tuser,   // [1:0] cmd

	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [31:0] pop_value, [38:32] fill_count, [39] zero
	output logic [1:0]       m_tuser    // [1:0] status
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int EXT_W = (CNT_W > smms_pkg::FILL_W) ? CNT_W : smms_pkg::FILL_W;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_POP_RD = 3'd1;  // waiting on RAM read of the top word
	localparam logic [2:0] S_SCAN   = 3'd2;  // issuing one read per cycle
	localparam logic [2:0] S_DRAIN  = 3'd3;  // last compare
	localparam logic [2:0] S_WR_MIN = 3'd4;  // max value into the min slot
	localparam logic [2:0] S_WR_MAX = 3'd5;  // min value into the max slot, result out

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;

	// word RAM
	logic [smms_pkg::WORD_W-1:0] mem [DEPTH];
	logic [smms_pkg::WORD_W-1:0] rd_data_q;
	logic [AW-1:0]               rd_addr;
	logic                        mem_we;
	logic [AW-1:0]               mem_wa;
	logic [smms_pkg::WORD_W-1:0] mem_wd;

	// scan compare stage
	logic                               valid_s1;
	logic [AW-1:0]                      idx_s1;
	logic signed [smms_pkg::WORD_W-1:0] min_w_q;
	logic signed [smms_pkg::WORD_W-1:0] max_w_q;
	logic [AW-1:0]                      min_idx_q;
	logic [AW-1:0]                      max_idx_q;
	logic signed [smms_pkg::WORD_W-1:0] scan_w;

	// output register
	logic                          m_valid_q;
	logic [smms_pkg::WORD_W-1:0]   out_pop_q;
	logic [smms_pkg::STATUS_W-1:0] out_st_q;
	logic [smms_pkg::FILL_W-1:0]   out_fill_q;

	logic                          slot_free;
	logic                          s_acc;
	logic                          is_full;
	logic                          is_empty;
	logic                          load_out;
	logic [smms_pkg::WORD_W-1:0]   out_pop_d;
	logic [smms_pkg::STATUS_W-1:0] out_st_d;
	logic [CNT_W-1:0]              fill_src;
	logic [EXT_W-1:0]              fill_ext;

	assign slot_free = !m_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && slot_free;
	assign s_acc     = s_tvalid && s_tready;
	assign is_full   = (count_q >= CNT_W'(DEPTH));
	assign is_empty  = (count_q == '0);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, out_fill_q, out_pop_q};
	assign m_tuser  = out_st_q;

	assign fill_ext = EXT_W'(fill_src);
	assign scan_w   = $signed(rd_data_q);

	// idle: address the top word for a pop; scan: walk from the bottom
	assign rd_addr = (state_q == S_SCAN) ? scan_q[AW-1:0] : AW'(count_q - 1'b1);

	always_comb begin
		mem_we    = 1'b0;
		mem_wa    = count_q[AW-1:0];
		mem_wd    = s_tdata;
		load_out  = 1'b0;
		out_pop_d = '0;
		out_st_d  = smms_pkg::ST_OK;
		fill_src  = count_q;
		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					case (s_tuser)
						smms_pkg::CMD_PUSH: begin
							load_out = 1'b1;
							if (is_full) begin
								out_st_d = smms_pkg::ST_FULL;
							end else begin
								mem_we   = 1'b1;
								fill_src = count_q + 1'b1;
							end
						end
						smms_pkg::CMD_POP: begin
							if (is_empty) begin
								load_out = 1'b1;
								out_st_d = smms_pkg::ST_EMPTY;
							end
						end
						smms_pkg::CMD_SWAP: begin
							load_out = is_empty;
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			S_POP_RD: begin
				if (slot_free) begin
					load_out  = 1'b1;
					out_pop_d = rd_data_q;
				end
			end
			S_WR_MIN: begin
				mem_we = 1'b1;
				mem_wa = min_idx_q;
				mem_wd = max_w_q;
			end
			S_WR_MAX: begin
				// rewriting while stalled is harmless
				mem_we   = 1'b1;
				mem_wa   = max_idx_q;
				mem_wd   = min_w_q;
				load_out = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	// sequencer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			scan_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						case (s_tuser)
							smms_pkg::CMD_PUSH: begin
								if (!is_full) begin
									count_q <= count_q + 1'b1;
								end
							end
							smms_pkg::CMD_POP: begin
								if (!is_empty) begin
									count_q <= count_q - 1'b1;
									state_q <= S_POP_RD;
								end
							end
							smms_pkg::CMD_SWAP: begin
								if (!is_empty) begin
									scan_q  <= '0;
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_POP_RD: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == count_q - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_WR_MIN;
				end
				S_WR_MIN: begin
					state_q <= S_WR_MAX;
				end
				S_WR_MAX: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[AW-1:0];
	end

	// running min/max; strict compares keep the first occurrence
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			if (idx_s1 == '0) begin
				min_w_q   <= scan_w;
				max_w_q   <= scan_w;
				min_idx_q <= '0;
				max_idx_q <= '0;
			end else begin
				if (scan_w < min_w_q) begin
					min_w_q   <= scan_w;
					min_idx_q <= idx_s1;
				end
				if (scan_w > max_w_q) begin
					max_w_q   <= scan_w;
					max_idx_q <= idx_s1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pop_q  <= out_pop_d;
			out_st_q   <= out_st_d;
			out_fill_q <= fill_ext[smms_pkg::FILL_W-1:0];
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_push_incr: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tuser == smms_pkg::CMD_PUSH && !is_full)
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("accepted push did not grow the stack");

	a_pop_decr: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tuser == smms_pkg::CMD_POP && !is_empty)
		|=> (count_q == $past(count_q) - 1'b1) && (state_q == S_POP_RD))
		else $error("accepted pop did not shrink the stack");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (scan_q < count_q))
		else $error("scan address beyond held entries");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_WR_MIN) |-> !load_out)
		else $error("result produced in the middle of a swap");

endmodule
`default_nettype wire
